FILE: rtl/core/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types and constants for the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

  localparam int TIME_W     = 32;
  localparam int LONG_W     = 16;
  localparam int DBL_W      = 16;
  localparam int POLL_W     = 8;
  localparam int NUM_BTN    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int EV_W       = 3;

  localparam logic [LONG_W-1:0] LONG_PRESS_RST = LONG_W'(1000);
  localparam logic [DBL_W-1:0]  DBL_WINDOW_RST = DBL_W'(300);
  localparam logic [POLL_W-1:0] POLL_INTV_RST  = POLL_W'(10);

  localparam int BTN_LEFT   = 0;
  localparam int BTN_MIDDLE = 1;
  localparam int BTN_RIGHT  = 2;

  typedef enum logic [2:0] {
    PH_RESET    = 3'd0,
    PH_IDLE     = 3'd1,
    PH_DEBOUNCE = 3'd2,
    PH_DOWN     = 3'd3,
    PH_WAIT     = 3'd4,
    PH_DOWN2    = 3'd5,
    PH_PRESSED  = 3'd6
  } phase_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE    = 3'd0,
    EV_START   = 3'd1,
    EV_LONG    = 3'd2,
    EV_DOUBLE  = 3'd3,
    EV_CLICK   = 3'd4,
    EV_RELEASE = 3'd5
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PRESS    = 2'd0,
    REG_DBL_WINDOW    = 2'd1,
    REG_POLL_INTERVAL = 2'd2,
    REG_DISPLAY_FLIP  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [LONG_W-1:0] long_press_ms;
    logic [DBL_W-1:0]  dbl_click_window_ms;
    logic [POLL_W-1:0] poll_interval_ms;
    logic              display_flip;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]               last_poll;
    logic [NUM_BTN-1:0][TIME_W-1:0]  stamp;
    phase_t [NUM_BTN-1:0]            phase;
  } row_t;

  localparam row_t ROW_RESET = '{
    last_poll: '0,
    stamp:     '0,
    phase:     '{PH_IDLE, PH_IDLE, PH_IDLE}
  };

endpackage

FILE: rtl/core/bgc_cfg.sv
// ----------------------------------------------------------------------------
// bgc_cfg
// Configuration register file: timing windows, poll interval and flip.
// ----------------------------------------------------------------------------
module bgc_cfg
  import bgc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_LONG_PRESS:    cfg_nxt.long_press_ms       = cfg_wdata[LONG_W-1:0];
        REG_DBL_WINDOW:    cfg_nxt.dbl_click_window_ms = cfg_wdata[DBL_W-1:0];
        REG_POLL_INTERVAL: cfg_nxt.poll_interval_ms    = cfg_wdata[POLL_W-1:0];
        REG_DISPLAY_FLIP:  cfg_nxt.display_flip        = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms       <= LONG_PRESS_RST;
      cfg_r.dbl_click_window_ms <= DBL_WINDOW_RST;
      cfg_r.poll_interval_ms    <= POLL_INTV_RST;
      cfg_r.display_flip        <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/core/bgc_state_mem.sv
// ----------------------------------------------------------------------------
// bgc_state_mem
// State row memory with registered read, reset-valid flag and write forwarding.
// ----------------------------------------------------------------------------
module bgc_state_mem
  import bgc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  row_t wr_row,
  output row_t rd_row
);

  row_t mem [0:0];
  row_t rd_data_r;
  row_t fwd_row_r;
  logic fwd_r;
  logic row_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[0] <= wr_row;
    end
    rd_data_r <= row_valid_r ? mem[0] : ROW_RESET;
    fwd_row_r <= wr_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r       <= 1'b0;
      row_valid_r <= 1'b0;
    end else begin
      fwd_r <= wr_en;
      if (wr_en) begin
        row_valid_r <= 1'b1;
      end
    end
  end

  // take the row just written over the stale read
  assign rd_row = fwd_r ? fwd_row_r : rd_data_r;

endmodule

FILE: rtl/core/bgc_button.sv
// ----------------------------------------------------------------------------
// bgc_button
// Per-button gesture state machine: next phase, press stamp and event.
// ----------------------------------------------------------------------------
module bgc_button
  import bgc_pkg::*;
(
  input  logic              enable,
  input  logic              down,
  input  logic [TIME_W-1:0] now,
  input  logic [LONG_W-1:0] long_press_ms,
  input  logic [DBL_W-1:0]  dbl_click_window_ms,
  input  phase_t            phase,
  input  logic [TIME_W-1:0] stamp,
  output phase_t            phase_nxt,
  output logic [TIME_W-1:0] stamp_nxt,
  output event_t            ev
);

  logic [TIME_W-1:0] held;
  logic [TIME_W-1:0] long_ext;
  logic [TIME_W-1:0] dbl_ext;

  assign held     = now - stamp;
  assign long_ext = {{(TIME_W-LONG_W){1'b0}}, long_press_ms};
  assign dbl_ext  = {{(TIME_W-DBL_W){1'b0}}, dbl_click_window_ms};

  always_comb begin
    phase_nxt = phase;
    stamp_nxt = stamp;
    if (enable) begin
      if (down) begin
        case (phase)
          PH_IDLE: begin
            phase_nxt = PH_DOWN;
            stamp_nxt = now;
          end
          PH_DOWN: begin
            if (held > long_ext) begin
              phase_nxt = PH_PRESSED;
            end
          end
          PH_WAIT: begin
            if (held < dbl_ext) begin
              phase_nxt = PH_DOWN2;
            end else begin
              phase_nxt = PH_DOWN;
              stamp_nxt = now;
            end
          end
          default: ;
        endcase
      end else begin
        case (phase)
          PH_RESET: phase_nxt = PH_IDLE;
          PH_DOWN: begin
            phase_nxt = PH_WAIT;
            stamp_nxt = now;
          end
          PH_WAIT: begin
            if (held > dbl_ext) begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_DOWN2: phase_nxt = PH_IDLE;
          PH_PRESSED: phase_nxt = PH_IDLE;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    ev = EV_NONE;
    if (enable) begin
      if (down) begin
        case (phase)
          PH_IDLE: ev = EV_START;
          PH_DOWN: begin
            if (held > long_ext) begin
              ev = EV_LONG;
            end
          end
          PH_WAIT: begin
            if (held < dbl_ext) begin
              ev = EV_DOUBLE;
            end else begin
              ev = EV_START;
            end
          end
          default: ;
        endcase
      end else begin
        case (phase)
          PH_DOWN:    ev = EV_CLICK;
          PH_PRESSED: ev = EV_RELEASE;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: rtl/core/button_gesture_classifier.sv
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Three-button click, double click and long press classifier.
//
// Each input item is one poll: a millisecond time, three switch levels and a
// rearm flag. Each accepted poll gives exactly one result item with the three
// button events, the poll-taken flag, the busy flag and the phase masks.
// Configuration writes use their own valid/ready channel (always ready) and
// must only be issued while no item is in flight.
// An accepted poll waits in the input stage; its result is then registered
// in the output register. Throughput: one item per cycle unless stalled;
// the button state row lives in a one-entry memory read every cycle, and
// the row an item writes is forwarded to the next item in the following cycle.
// Reset: the state row reads as all buttons idle with zero stamps and zero
// last poll time until first written; registers take their defaults.
// Output stall: the output register holds its item; one more item waits in
// the input stage, after which in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
module button_gesture_classifier
  import bgc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TIME_W-1:0]     in_time_ms,
  input  logic                  in_level_sw1,
  input  logic                  in_level_sw2,
  input  logic                  in_level_sw3,
  input  logic                  in_rearm,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [EV_W-1:0]       out_event_left,
  output logic [EV_W-1:0]       out_event_middle,
  output logic [EV_W-1:0]       out_event_right,
  output logic                  out_poll_taken,
  output logic                  out_busy_res,
  output logic [NUM_BTN-1:0]    out_pressed_mask,
  output logic [NUM_BTN-1:0]    out_held_mask,
  output logic [NUM_BTN-1:0]    out_reset_mask,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;

  logic              s1_valid_r;
  logic [TIME_W-1:0] s1_time_r;
  logic [NUM_BTN-1:0] s1_sw_r;
  logic              s1_rearm_r;
  logic              adv;

  row_t row_cur;
  row_t row_nxt;
  logic [TIME_W-1:0] elapsed;
  logic              taken;
  logic [NUM_BTN-1:0] btn_down;
  phase_t [NUM_BTN-1:0] btn_phase_nxt;
  logic [NUM_BTN-1:0][TIME_W-1:0] btn_stamp_nxt;
  event_t [NUM_BTN-1:0] btn_ev;
  logic [NUM_BTN-1:0] pmask;
  logic [NUM_BTN-1:0] hmask;
  logic [NUM_BTN-1:0] rmask;
  logic [NUM_BTN-1:0] bmask;

  logic               out_valid_r;
  event_t [NUM_BTN-1:0] out_ev_r;
  logic               out_taken_r;
  logic               out_busy_r;
  logic [NUM_BTN-1:0] out_pmask_r;
  logic [NUM_BTN-1:0] out_hmask_r;
  logic [NUM_BTN-1:0] out_rmask_r;

  bgc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_time_r  <= in_time_ms;
      s1_sw_r    <= {in_level_sw3, in_level_sw2, in_level_sw1};
      s1_rearm_r <= in_rearm;
    end
  end

  bgc_state_mem u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (s1_valid_r && adv),
    .wr_row (row_nxt),
    .rd_row (row_cur)
  );

  assign elapsed = s1_time_r - row_cur.last_poll;
  assign taken   = !s1_rearm_r &&
                   (elapsed >= {{(TIME_W-POLL_W){1'b0}}, cfg.poll_interval_ms});

  // swap outer switches when flipped
  always_comb begin
    btn_down[BTN_MIDDLE] = s1_sw_r[BTN_MIDDLE];
    btn_down[BTN_LEFT]   = cfg.display_flip ? s1_sw_r[BTN_RIGHT] : s1_sw_r[BTN_LEFT];
    btn_down[BTN_RIGHT]  = cfg.display_flip ? s1_sw_r[BTN_LEFT]  : s1_sw_r[BTN_RIGHT];
  end

  for (genvar g = 0; g < NUM_BTN; g++) begin : g_btn
    bgc_button u_btn (
      .enable              (taken),
      .down                (btn_down[g]),
      .now                 (s1_time_r),
      .long_press_ms       (cfg.long_press_ms),
      .dbl_click_window_ms (cfg.dbl_click_window_ms),
      .phase               (row_cur.phase[g]),
      .stamp               (row_cur.stamp[g]),
      .phase_nxt           (btn_phase_nxt[g]),
      .stamp_nxt           (btn_stamp_nxt[g]),
      .ev                  (btn_ev[g])
    );
  end

  always_comb begin
    row_nxt.last_poll = taken ? s1_time_r : row_cur.last_poll;
    row_nxt.stamp     = btn_stamp_nxt;
    for (int i = 0; i < NUM_BTN; i++) begin
      row_nxt.phase[i] = s1_rearm_r ? PH_RESET : btn_phase_nxt[i];
      bmask[i] = row_nxt.phase[i] > PH_IDLE;
      pmask[i] = row_nxt.phase[i] > PH_DEBOUNCE;
      hmask[i] = row_nxt.phase[i] == PH_PRESSED;
      rmask[i] = row_nxt.phase[i] == PH_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && adv) begin
      out_ev_r    <= btn_ev;
      out_taken_r <= taken;
      out_busy_r  <= |bmask;
      out_pmask_r <= pmask;
      out_hmask_r <= hmask;
      out_rmask_r <= rmask;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_left   = out_ev_r[BTN_LEFT];
  assign out_event_middle = out_ev_r[BTN_MIDDLE];
  assign out_event_right  = out_ev_r[BTN_RIGHT];
  assign out_poll_taken   = out_taken_r;
  assign out_busy_res     = out_busy_r;
  assign out_pressed_mask = out_pmask_r;
  assign out_held_mask    = out_hmask_r;
  assign out_reset_mask   = out_rmask_r;

  a_held_in_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_hmask_r & ~out_pmask_r) == '0))
    else $error("held button not in pressed mask");

  a_reset_not_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_rmask_r & out_pmask_r) == '0))
    else $error("button both rearmed and pressed");

  a_no_event_untaken: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_taken_r) |->
      (out_ev_r[BTN_LEFT] == EV_NONE && out_ev_r[BTN_MIDDLE] == EV_NONE &&
       out_ev_r[BTN_RIGHT] == EV_NONE))
    else $error("event reported on an untaken poll");

  a_pressed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_pmask_r != '0)) |-> out_busy_r)
    else $error("pressed button without busy flag");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> s1_valid_r && $stable(s1_time_r))
    else $error("input stage lost its item during stall");

endmodule

FILE: tb/gesture_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gesture_checker
// Watches the poll, result and register channels of the gesture classifier.
// Keeps its own copy of the button phases, press stamps, last poll time and
// registers, works out the result of every accepted poll and compares each
// accepted result field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module gesture_checker
  import bgc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [TIME_W-1:0]     in_time_ms,
  input  logic                  in_level_sw1,
  input  logic                  in_level_sw2,
  input  logic                  in_level_sw3,
  input  logic                  in_rearm,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [EV_W-1:0]       out_event_left,
  input  logic [EV_W-1:0]       out_event_middle,
  input  logic [EV_W-1:0]       out_event_right,
  input  logic                  out_poll_taken,
  input  logic                  out_busy_res,
  input  logic [NUM_BTN-1:0]    out_pressed_mask,
  input  logic [NUM_BTN-1:0]    out_held_mask,
  input  logic [NUM_BTN-1:0]    out_reset_mask,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    event_t             ev_left;
    event_t             ev_middle;
    event_t             ev_right;
    logic               taken;
    logic               busy;
    logic [NUM_BTN-1:0] pressed;
    logic [NUM_BTN-1:0] held;
    logic [NUM_BTN-1:0] rearmed;
  } poll_result_t;

  poll_result_t      expected_polls[$];
  cfg_t              regs;
  phase_t            phase [NUM_BTN];
  logic [TIME_W-1:0] stamp [NUM_BTN];
  logic [TIME_W-1:0] last_poll;

  task automatic report_mismatch(string what, logic [EV_W-1:0] got, logic [EV_W-1:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic event_t advance_button(int slot, logic down, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] held_ms;
    event_t            ev;
    held_ms = now - stamp[slot];
    ev = EV_NONE;
    if (down) begin
      case (phase[slot])
        PH_IDLE: begin
          ev = EV_START;
          phase[slot] = PH_DOWN;
          stamp[slot] = now;
        end
        PH_DOWN: begin
          if (held_ms > TIME_W'(regs.long_press_ms)) begin
            ev = EV_LONG;
            phase[slot] = PH_PRESSED;
          end
        end
        PH_WAIT: begin
          if (held_ms < TIME_W'(regs.dbl_click_window_ms)) begin
            ev = EV_DOUBLE;
            phase[slot] = PH_DOWN2;
          end else begin
            ev = EV_START;
            phase[slot] = PH_DOWN;
            stamp[slot] = now;
          end
        end
        default: ;
      endcase
    end else begin
      case (phase[slot])
        PH_RESET: phase[slot] = PH_IDLE;
        PH_DOWN: begin
          ev = EV_CLICK;
          phase[slot] = PH_WAIT;
          stamp[slot] = now;
        end
        PH_WAIT: begin
          if (held_ms > TIME_W'(regs.dbl_click_window_ms)) phase[slot] = PH_IDLE;
        end
        PH_DOWN2: phase[slot] = PH_IDLE;
        PH_PRESSED: begin
          ev = EV_RELEASE;
          phase[slot] = PH_IDLE;
        end
        default: ;
      endcase
    end
    return ev;
  endfunction

  function automatic poll_result_t classify_poll(logic [TIME_W-1:0] now, logic sw1, logic sw2,
                                                 logic sw3, logic rearm);
    poll_result_t      r;
    logic [TIME_W-1:0] since;
    r = '0;
    since = now - last_poll;
    if (rearm) begin
      for (int b = 0; b < NUM_BTN; b++) phase[b] = PH_RESET;
    end else if (since >= TIME_W'(regs.poll_interval_ms)) begin
      last_poll = now;
      r.taken = 1'b1;
      r.ev_left = advance_button(BTN_LEFT, regs.display_flip ? sw3 : sw1, now);
      r.ev_right = advance_button(BTN_RIGHT, regs.display_flip ? sw1 : sw3, now);
      r.ev_middle = advance_button(BTN_MIDDLE, sw2, now);
    end
    for (int b = 0; b < NUM_BTN; b++) begin
      if (phase[b] > PH_IDLE) r.busy = 1'b1;
      r.pressed[b] = (phase[b] > PH_DEBOUNCE);
      r.held[b] = (phase[b] == PH_PRESSED);
      r.rearmed[b] = (phase[b] == PH_RESET);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    poll_result_t want;
    if (!rst_n) begin
      regs.long_press_ms = LONG_PRESS_RST;
      regs.dbl_click_window_ms = DBL_WINDOW_RST;
      regs.poll_interval_ms = POLL_INTV_RST;
      regs.display_flip = 1'b0;
      for (int b = 0; b < NUM_BTN; b++) begin
        phase[b] = PH_IDLE;
        stamp[b] = '0;
      end
      last_poll = '0;
      expected_polls.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_polls.size() == 0) begin
          report_mismatch("result with no poll waiting", out_event_left, EV_NONE);
        end else begin
          want = expected_polls.pop_front();
          if (out_event_left !== want.ev_left)
            report_mismatch("event_left", out_event_left, want.ev_left);
          if (out_event_middle !== want.ev_middle)
            report_mismatch("event_middle", out_event_middle, want.ev_middle);
          if (out_event_right !== want.ev_right)
            report_mismatch("event_right", out_event_right, want.ev_right);
          if (out_poll_taken !== want.taken)
            report_mismatch("poll_taken", EV_W'(out_poll_taken), EV_W'(want.taken));
          if (out_busy_res !== want.busy)
            report_mismatch("busy_res", EV_W'(out_busy_res), EV_W'(want.busy));
          if (out_pressed_mask !== want.pressed)
            report_mismatch("pressed_mask", out_pressed_mask, want.pressed);
          if (out_held_mask !== want.held)
            report_mismatch("held_mask", out_held_mask, want.held);
          if (out_reset_mask !== want.rearmed)
            report_mismatch("reset_mask", out_reset_mask, want.rearmed);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LONG_PRESS:    regs.long_press_ms = cfg_wdata[LONG_W-1:0];
          REG_DBL_WINDOW:    regs.dbl_click_window_ms = cfg_wdata[DBL_W-1:0];
          REG_POLL_INTERVAL: regs.poll_interval_ms = cfg_wdata[POLL_W-1:0];
          REG_DISPLAY_FLIP:  regs.display_flip = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_polls.push_back(classify_poll(in_time_ms, in_level_sw1, in_level_sw2,
                                               in_level_sw3, in_rearm));
    end
    pending <= expected_polls.size();
  end

endmodule

FILE: tb/tb_button_gesture_classifier.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_button_gesture_classifier
// Poll stimulus and verdict for the button gesture classifier.
// A directed run walks every button gesture, the poll interval boundary,
// time wrap and rearm; random phases then replay press sequences under
// several register settings, with sender gaps, receiver stalls and two long
// receiver hold-offs. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_button_gesture_classifier;
  import bgc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 400;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [TIME_W-1:0]     in_time_ms;
  logic                  in_level_sw1;
  logic                  in_level_sw2;
  logic                  in_level_sw3;
  logic                  in_rearm;
  logic                  out_valid;
  logic                  out_ready;
  logic [EV_W-1:0]       out_event_left;
  logic [EV_W-1:0]       out_event_middle;
  logic [EV_W-1:0]       out_event_right;
  logic                  out_poll_taken;
  logic                  out_busy_res;
  logic [NUM_BTN-1:0]    out_pressed_mask;
  logic [NUM_BTN-1:0]    out_held_mask;
  logic [NUM_BTN-1:0]    out_reset_mask;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int                fail_count;
  int                pending;
  int                idle_pct;
  int                stall_pct;
  int                hold_reqs;
  int                holds_done;
  int                quiet_cycles = 0;
  logic [TIME_W-1:0] now_ms;
  logic [2:0]        levels;

  always #5 clk = ~clk;

  button_gesture_classifier DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_time_ms       (in_time_ms),
    .in_level_sw1     (in_level_sw1),
    .in_level_sw2     (in_level_sw2),
    .in_level_sw3     (in_level_sw3),
    .in_rearm         (in_rearm),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_left   (out_event_left),
    .out_event_middle (out_event_middle),
    .out_event_right  (out_event_right),
    .out_poll_taken   (out_poll_taken),
    .out_busy_res     (out_busy_res),
    .out_pressed_mask (out_pressed_mask),
    .out_held_mask    (out_held_mask),
    .out_reset_mask   (out_reset_mask),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  gesture_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_time_ms       (in_time_ms),
    .in_level_sw1     (in_level_sw1),
    .in_level_sw2     (in_level_sw2),
    .in_level_sw3     (in_level_sw3),
    .in_rearm         (in_rearm),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_left   (out_event_left),
    .out_event_middle (out_event_middle),
    .out_event_right  (out_event_right),
    .out_poll_taken   (out_poll_taken),
    .out_busy_res     (out_busy_res),
    .out_pressed_mask (out_pressed_mask),
    .out_held_mask    (out_held_mask),
    .out_reset_mask   (out_reset_mask),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // hold off the receiver for a long stretch on request, else stall at random
  initial begin
    out_ready = 1'b0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_poll(logic [TIME_W-1:0] t, logic [2:0] sw, logic rearm);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_time_ms <= t;
    in_level_sw1 <= sw[0];
    in_level_sw2 <= sw[1];
    in_level_sw3 <= sw[2];
    in_rearm <= rearm;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(logic [LONG_W-1:0] long_ms, logic [DBL_W-1:0] dbl_ms,
                              logic [POLL_W-1:0] poll_ms, logic flip);
    write_reg(REG_LONG_PRESS, long_ms);
    write_reg(REG_DBL_WINDOW, dbl_ms);
    write_reg(REG_POLL_INTERVAL, CFG_DATA_W'(poll_ms));
    write_reg(REG_DISPLAY_FLIP, CFG_DATA_W'(flip));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_polls();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // mostly held or toggled levels at time steps up to span, some random jumps
  task automatic random_polls(int count, int span);
    logic [2:0] sw;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 8) begin
        now_ms = $urandom();
        sw = 3'($urandom());
      end else begin
        now_ms = now_ms + TIME_W'($urandom_range(span));
        for (int b = 0; b < NUM_BTN; b++)
          if ($urandom_range(99) < 20) levels[b] = ~levels[b];
        sw = levels;
      end
      send_poll(now_ms, sw, $urandom_range(99) < 3);
    end
  endtask

  task automatic random_phase(int count, int send_idle, int recv_stall, logic long_hold);
    drain_polls();
    program_regs(LONG_W'($urandom_range(300)), DBL_W'($urandom_range(300)),
                 POLL_W'($urandom_range(30)), 1'($urandom()));
    idle_pct = send_idle;
    stall_pct <= recv_stall;
    if (long_hold) hold_reqs <= hold_reqs + 1;
    random_polls(count, 60);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_time_ms = '0;
    in_level_sw1 = 1'b0;
    in_level_sw2 = 1'b0;
    in_level_sw3 = 1'b0;
    in_rearm = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_LONG_PRESS;
    cfg_wdata = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_reqs = 0;
    now_ms = '0;
    levels = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_poll(32'd0, 3'b000, 1'b0);
    send_poll(32'd5, 3'b000, 1'b0);
    send_poll(32'd10, 3'b001, 1'b0);
    send_poll(32'd20, 3'b001, 1'b0);
    send_poll(32'd30, 3'b000, 1'b0);
    send_poll(32'd100, 3'b001, 1'b0);
    send_poll(32'd110, 3'b000, 1'b0);
    send_poll(32'd120, 3'b010, 1'b0);
    send_poll(32'd1200, 3'b010, 1'b0);
    send_poll(32'd1210, 3'b010, 1'b0);
    send_poll(32'd1220, 3'b000, 1'b0);
    send_poll(32'd1230, 3'b100, 1'b0);
    send_poll(32'd1240, 3'b000, 1'b0);
    send_poll(32'd1600, 3'b100, 1'b0);
    send_poll(32'd1610, 3'b000, 1'b0);
    send_poll(32'd1620, 3'b000, 1'b0);
    send_poll(32'd2000, 3'b000, 1'b0);
    send_poll(32'hFFFF_FFFF, 3'b111, 1'b0);
    send_poll(32'd9, 3'b111, 1'b0);
    send_poll(32'd12345, 3'b111, 1'b1);
    send_poll(32'd30, 3'b111, 1'b0);
    send_poll(32'd40, 3'b000, 1'b0);
    send_poll(32'd41, 3'b000, 1'b0);
    send_poll(32'd60, 3'b111, 1'b0);
    now_ms = 32'd60;

    drain_polls();
    program_regs('0, '0, '0, 1'b1);
    random_polls(150, 4);

    drain_polls();
    program_regs('1, '1, '1, 1'b0);
    idle_pct = 71;
    random_polls(150, 40000);

    random_phase(250, 0, 71, 1'b0);
    random_phase(250, 15, 15, 1'b1);
    random_phase(200, 0, 0, 1'b1);

    drain_polls();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/bgc_pkg.sv
rtl/core/bgc_cfg.sv
rtl/core/bgc_state_mem.sv
rtl/core/bgc_button.sv
rtl/core/button_gesture_classifier.sv
tb/gesture_checker.sv
tb/tb_button_gesture_classifier.sv
